// File: rtl/cbq_pkg.sv
// ----------------------------------------------------------------------------
// Cel band quantizer package
// Fixed-point formats, configuration codes and the configuration bundle
// shared by the quantizer modules and channel interfaces.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned MAX_BANDS = 16;

  localparam int unsigned IN_W       = 18;
  localparam int unsigned OUT_W      = 17;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned SOFT_W     = 9;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned SOFT_FRAC  = 8;
  localparam int unsigned SOFT_ONE   = 256;
  localparam int unsigned SOFT_IDX_W = 8;

  localparam int unsigned BAND_COUNT_RST = 4;
  localparam int unsigned SOFTNESS_RST   = 0;

  localparam int unsigned STEPS_W = $clog2(MAX_BANDS);
  localparam int unsigned BANDS_W = ($clog2(MAX_BANDS + 1) > CNT_W) ?
                                    $clog2(MAX_BANDS + 1) : CNT_W;

  localparam int unsigned NUM_W     = STEPS_W + FRAC_BITS + 1;
  localparam int unsigned STEPS_K   = NUM_W + STEPS_W;
  localparam int unsigned STEPS_R_W = STEPS_K + 1;

  localparam int unsigned DN_W     = FRAC_BITS + SOFT_FRAC + 1;
  localparam int unsigned SOFT_K   = DN_W + SOFT_FRAC;
  localparam int unsigned SOFT_R_W = SOFT_K + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_SOFTNESS = CFG_IDX_W'(1);

  typedef struct packed {
    logic [STEPS_W-1:0]   steps;
    logic [SOFT_W-1:0]    softness;
    logic [STEPS_R_W-1:0] steps_recip;
    logic [SOFT_R_W-1:0]  soft_recip;
  } cfg_t;

  // Rounded-up reciprocal ceil(2^k / d) by long division, used on constants only.
  function automatic logic [63:0] recip_f(input int unsigned k, input int unsigned d);
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    num = (64'd1 << k) + 64'(d) - 64'd1;
    quo = '0;
    rem = '0;
    if (d == 0) begin
      return '0;
    end
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = {quo[62:0], 1'b0};
      if (rem >= 64'(d)) begin
        rem = rem - 64'(d);
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

endpackage

// File: rtl/cbq_in_if.sv
// ----------------------------------------------------------------------------
// Cel band quantizer input channel
// Valid/ready channel carrying one signed intensity word.
// ----------------------------------------------------------------------------
interface cbq_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbq_pkg::IN_W-1:0]     intensity;

  modport source (output valid, output intensity, input ready);
  modport sink   (input valid, input intensity, output ready);
endinterface

// File: rtl/cbq_out_if.sv
// ----------------------------------------------------------------------------
// Cel band quantizer output channel
// Valid/ready channel carrying one banded intensity word.
// ----------------------------------------------------------------------------
interface cbq_out_if;
  logic                         valid;
  logic                         ready;
  logic [cbq_pkg::OUT_W-1:0]    banded_intensity;

  modport source (output valid, output banded_intensity, input ready);
  modport sink   (input valid, input banded_intensity, output ready);
endinterface

// File: rtl/cbq_cfg.sv
// ----------------------------------------------------------------------------
// Cel band quantizer configuration registers
// Holds the saturated band step count and softness together with their
// reciprocals, looked up at write time from constant tables.
// ----------------------------------------------------------------------------
module cbq_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cbq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output cbq_pkg::cfg_t                    cfg_o
);

  localparam int unsigned SW    = cbq_pkg::STEPS_W;
  localparam int unsigned BW    = cbq_pkg::BANDS_W;
  localparam int unsigned SRW   = cbq_pkg::STEPS_R_W;
  localparam int unsigned FRW   = cbq_pkg::SOFT_R_W;
  localparam int unsigned RST_BANDS = (cbq_pkg::BAND_COUNT_RST > cbq_pkg::MAX_BANDS) ?
                                      cbq_pkg::MAX_BANDS :
                                      ((cbq_pkg::BAND_COUNT_RST < 1) ? 1 :
                                       cbq_pkg::BAND_COUNT_RST);
  localparam int unsigned RST_SOFT_D = (cbq_pkg::SOFTNESS_RST == 0) ?
                                       cbq_pkg::SOFT_ONE : cbq_pkg::SOFTNESS_RST;

  logic [SRW-1:0] steps_recip_tab [2**SW];
  logic [FRW-1:0] soft_recip_tab  [2**cbq_pkg::SOFT_IDX_W];

  for (genvar g = 0; g < 2**SW; g++) begin : g_steps_tab
    assign steps_recip_tab[g] = SRW'(cbq_pkg::recip_f(cbq_pkg::STEPS_K, g));
  end

  // Entry zero stands for a full softness of one.
  for (genvar g = 0; g < 2**cbq_pkg::SOFT_IDX_W; g++) begin : g_soft_tab
    assign soft_recip_tab[g] = FRW'(cbq_pkg::recip_f(cbq_pkg::SOFT_K,
                                    (g == 0) ? cbq_pkg::SOFT_ONE : g));
  end

  logic [SW-1:0]              steps_q, steps_d;
  logic [cbq_pkg::SOFT_W-1:0] soft_q, soft_d;
  logic [SRW-1:0]             steps_recip_q, steps_recip_d;
  logic [FRW-1:0]             soft_recip_q, soft_recip_d;
  logic [BW-1:0]              bands_c;
  logic [SW-1:0]              steps_c;
  logic [cbq_pkg::SOFT_W-1:0] soft_c;

  always_comb begin
    bands_c = BW'(cfg_data_i[cbq_pkg::CNT_W-1:0]);
    if (bands_c == '0) begin
      bands_c = BW'(1);
    end else if (bands_c > BW'(cbq_pkg::MAX_BANDS)) begin
      bands_c = BW'(cbq_pkg::MAX_BANDS);
    end
    steps_c = SW'(bands_c - BW'(1));
    soft_c  = cfg_data_i[cbq_pkg::SOFT_W-1:0];
    if (soft_c > cbq_pkg::SOFT_W'(cbq_pkg::SOFT_ONE)) begin
      soft_c = cbq_pkg::SOFT_W'(cbq_pkg::SOFT_ONE);
    end

    steps_d       = steps_q;
    soft_d        = soft_q;
    steps_recip_d = steps_recip_q;
    soft_recip_d  = soft_recip_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cbq_pkg::CFG_BAND_COUNT: begin
          steps_d       = steps_c;
          steps_recip_d = steps_recip_tab[steps_c];
        end
        cbq_pkg::CFG_BAND_SOFTNESS: begin
          soft_d       = soft_c;
          soft_recip_d = soft_recip_tab[soft_c[cbq_pkg::SOFT_IDX_W-1:0]];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q       <= SW'(RST_BANDS - 1);
      soft_q        <= cbq_pkg::SOFT_W'(cbq_pkg::SOFTNESS_RST);
      steps_recip_q <= SRW'(cbq_pkg::recip_f(cbq_pkg::STEPS_K, RST_BANDS - 1));
      soft_recip_q  <= FRW'(cbq_pkg::recip_f(cbq_pkg::SOFT_K, RST_SOFT_D));
    end else begin
      steps_q       <= steps_d;
      soft_q        <= soft_d;
      steps_recip_q <= steps_recip_d;
      soft_recip_q  <= soft_recip_d;
    end
  end

  assign cfg_o.steps       = steps_q;
  assign cfg_o.softness    = soft_q;
  assign cfg_o.steps_recip = steps_recip_q;
  assign cfg_o.soft_recip  = soft_recip_q;

endmodule

// File: rtl/cel_band_quantizer.sv
// Throughput: one word per cycle while the output accepts words;
// the ten-stage pipeline has one multiplier per stage at most.
// A stall at the output freezes every stage together, so no word is lost or repeated.
// Reset clears all valid bits and sets four bands with zero softness.
// ----------------------------------------------------------------------------
// Cel band quantizer
// Snaps a fixed-point light intensity onto a ladder of brightness bands,
// with optional smoothstep blending at each band boundary.
// ----------------------------------------------------------------------------
module cel_band_quantizer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cbq_in_if.sink                           in_i,
  cbq_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cbq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned F    = cbq_pkg::FRAC_BITS;
  localparam int unsigned SW   = cbq_pkg::STEPS_W;
  localparam int unsigned NW   = cbq_pkg::NUM_W;
  localparam int unsigned DW   = cbq_pkg::DN_W;
  localparam int unsigned SC_W = F + SW;
  localparam int unsigned DP_W = DW + cbq_pkg::SOFT_R_W;
  localparam int unsigned QP_W = NW + cbq_pkg::STEPS_R_W;
  localparam int unsigned NSTG = 10;

  typedef struct packed {
    logic                      byp;
    logic [cbq_pkg::OUT_W-1:0] bval;
    logic                      tz;
    logic                      tone;
    logic [SW-1:0]             lower;
    logic [NW-1:0]             numh;
  } pass_t;

  cbq_pkg::cfg_t cfg;

  cbq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic            en;
  logic [NSTG-1:0] vld_q;
  pass_t           pass_q [NSTG];
  pass_t           p1_d, p2_d;
  logic [SW-1:0]   half_steps;

  logic [SC_W-1:0]           scaled_q, scaled_d;
  logic [DW-1:0]             divnum_q, divnum_d;
  logic [DP_W-1:0]           dprod_q, dprod_d;
  logic [F:0]                t_q, t_d;
  logic [F+1:0]              w4_q, w4_d, w5_q, w6_q;
  logic [2*F+1:0]            tsq_q, tsq_d;
  logic [F:0]                t2_q, t2_d;
  logic [2*F+2:0]            braw_q, braw_d;
  logic [NW-1:0]             num_q, num_d;
  logic [QP_W-1:0]           qprod_q, qprod_d;
  logic [cbq_pkg::OUT_W-1:0] banded_q, banded_d;

  assign en         = !vld_q[NSTG-1] || out_o.ready;
  assign in_i.ready = en;
  assign half_steps = cfg.steps >> 1;

  always_comb begin
    p1_d.byp   = in_i.intensity[cbq_pkg::IN_W-1] || (in_i.intensity == '0) ||
                 (|in_i.intensity[cbq_pkg::IN_W-2:F]) || (cfg.steps == '0);
    p1_d.bval  = in_i.intensity[cbq_pkg::IN_W-1] ? '0 :
                 in_i.intensity[cbq_pkg::OUT_W-1:0];
    p1_d.tz    = 1'b0;
    p1_d.tone  = 1'b0;
    p1_d.lower = '0;
    p1_d.numh  = '0;
    scaled_d   = SC_W'(in_i.intensity[F-1:0]) * SC_W'(cfg.steps);
  end

  logic [SC_W:0] hrnd;
  logic [SW:0]   band;
  logic [SW-1:0] bandc;
  logic [F:0]    s_w;
  logic [F+2:0]  n, twos;
  logic [2*F+1:0] xnum;

  always_comb begin
    hrnd  = {1'b0, scaled_q} + ((SC_W + 1)'(1) << (F - 1));
    band  = hrnd[SC_W:F];
    bandc = (band > {1'b0, cfg.steps}) ? cfg.steps : band[SW-1:0];
    s_w   = (F + 1)'(cfg.softness) << (F - cbq_pkg::SOFT_FRAC);
    n     = {2'b00, scaled_q[F-1:0], 1'b0} - ((F + 3)'(1) << F) + (F + 3)'(s_w);
    twos  = (F + 3)'(s_w) << 1;
    xnum  = ((2 * F + 2)'(n[F:0]) << F) + (2 * F + 2)'(s_w);

    p2_d       = pass_q[0];
    p2_d.lower = scaled_q[SC_W-1:F];
    p2_d.numh  = {1'b0, bandc, {F{1'b0}}} + NW'(half_steps);
    p2_d.tz    = n[F+2] || (n == '0);
    p2_d.tone  = !n[F+2] && (n >= twos);
    divnum_d   = xnum[2*F+1:F-cbq_pkg::SOFT_FRAC+1];
  end

  assign dprod_d = DP_W'(divnum_q) * DP_W'(cfg.soft_recip);

  always_comb begin
    if (pass_q[2].tz) begin
      t_d = '0;
    end else if (pass_q[2].tone) begin
      t_d = (F + 1)'(1) << F;
    end else begin
      t_d = dprod_q[cbq_pkg::SOFT_K +: F+1];
    end
    w4_d = ((F + 2)'(3) << F) - {t_d, 1'b0};
  end

  assign tsq_d  = (2 * F + 2)'(t_q) * (2 * F + 2)'(t_q);
  assign t2_d   = (F + 1)'(((2 * F + 2)'(tsq_q) + ((2 * F + 2)'(1) << (F - 1))) >> F);
  assign braw_d = (2 * F + 3)'(t2_q) * (2 * F + 3)'(w6_q);

  logic [2*F+2:0] bsum;
  logic [NW-1:0]  nums;

  always_comb begin
    bsum = braw_q + ((2 * F + 3)'(1) << (F - 1));
    nums = {1'b0, pass_q[6].lower, {F{1'b0}}} + NW'(bsum[2*F+2:F]) + NW'(half_steps);
    num_d = (cfg.softness == '0) ? pass_q[6].numh : nums;
  end

  assign qprod_d = QP_W'(num_q) * QP_W'(cfg.steps_recip);

  logic [F+1:0] q;

  always_comb begin
    q = qprod_q[cbq_pkg::STEPS_K +: F+2];
    if ((cfg.softness != '0) && (q > ((F + 2)'(1) << F))) begin
      q = (F + 2)'(1) << F;
    end
    banded_d = pass_q[8].byp ? pass_q[8].bval : cbq_pkg::OUT_W'(q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pass_q[0] <= p1_d;
      pass_q[1] <= p2_d;
      for (int k = 2; k < NSTG; k++) begin
        pass_q[k] <= pass_q[k-1];
      end
      scaled_q <= scaled_d;
      divnum_q <= divnum_d;
      dprod_q  <= dprod_d;
      t_q      <= t_d;
      w4_q     <= w4_d;
      tsq_q    <= tsq_d;
      w5_q     <= w4_q;
      t2_q     <= t2_d;
      w6_q     <= w5_q;
      braw_q   <= braw_d;
      num_q    <= num_d;
      qprod_q  <= qprod_d;
      banded_q <= banded_d;
    end
  end

  assign out_o.valid            = vld_q[NSTG-1];
  assign out_o.banded_intensity = banded_q;

  a_quant_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NSTG-1] && !pass_q[NSTG-1].byp |->
      banded_q <= (cbq_pkg::OUT_W'(1) << F))
    else $error("quantized word above one");

  a_blend_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && !pass_q[3].byp && (cfg.softness != '0) |-> t_q <= ((F + 1)'(1) << F))
    else $error("smoothstep position above one");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

endmodule
